>>> sv/piaw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI regulator package
// Field widths, register map, reset values and saturation helper shared by
// the PI regulator with back-calculation anti-windup.
// ----------------------------------------------------------------------------
package piaw_pkg;

	localparam int GAIN_W  = 15;
	localparam int LIMIT_W = 16;
	localparam int WIDE_W  = 32;
	localparam int SAMP_W  = 16;
	localparam int ERR_W   = 17;
	localparam int DRIVE_W = 16;
	localparam int PROD_W  = 32;
	localparam int ACC_W   = 40;
	localparam int CMP_W   = 38;

	localparam int MUL_STEPS = GAIN_W;
	localparam int DIV_STEPS = WIDE_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
	localparam int REM_W     = GAIN_W + 1;

	localparam int ANTIWINDUP_GAIN_DEF = 1;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PROP_DIVISOR  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_DIVISOR = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OUT_UPPER     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OUT_LOWER     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_UPPER   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_LOWER   = 3'd7;

	localparam logic [GAIN_W-1:0]         PROP_GAIN_RST     = 15'd8000;
	localparam logic [GAIN_W-1:0]         PROP_DIVISOR_RST  = 15'd128;
	localparam logic [GAIN_W-1:0]         INTEG_GAIN_RST    = 15'd10;
	localparam logic [GAIN_W-1:0]         INTEG_DIVISOR_RST = 15'd1;
	localparam logic signed [LIMIT_W-1:0] OUT_UPPER_RST     = 16'sd6000;
	localparam logic signed [LIMIT_W-1:0] OUT_LOWER_RST     = -16'sd6000;
	localparam logic signed [WIDE_W-1:0]  INTEG_UPPER_RST   = 32'sd6000;
	localparam logic signed [WIDE_W-1:0]  INTEG_LOWER_RST   = -32'sd6000;

	localparam logic signed [WIDE_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [WIDE_W-1:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [GAIN_W-1:0]         prop_gain;
		logic [GAIN_W-1:0]         prop_divisor;
		logic [GAIN_W-1:0]         integ_gain;
		logic [GAIN_W-1:0]         integ_divisor;
		logic signed [LIMIT_W-1:0] out_upper;
		logic signed [LIMIT_W-1:0] out_lower;
		logic signed [WIDE_W-1:0]  integ_upper;
		logic signed [WIDE_W-1:0]  integ_lower;
	} cfg_t;

	// Saturates a 33-bit signed value to the signed 32-bit range.
	function automatic logic signed [WIDE_W-1:0] sat33(input logic signed [WIDE_W:0] v);
		logic signed [WIDE_W-1:0] r;
		if (v[WIDE_W] != v[WIDE_W-1]) begin
			r = v[WIDE_W] ? S32_MIN : S32_MAX;
		end else begin
			r = v[WIDE_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> sv/piaw_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI regulator sample channel
// Valid/ready channel carrying one reference and one feedback sample a beat.
// ----------------------------------------------------------------------------
interface piaw_in_if import piaw_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [SAMP_W-1:0] reference;
	logic signed [SAMP_W-1:0] feedback;

	modport source (output valid, output reference, output feedback, input ready);
	modport sink (input valid, input reference, input feedback, output ready);
endinterface

>>> sv/piaw_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI regulator result channel
// Valid/ready channel carrying the limited drive, the unlimited sum and the
// control error of one sample a beat.
// ----------------------------------------------------------------------------
interface piaw_out_if import piaw_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;
	logic signed [WIDE_W-1:0]  unlimited_sum;
	logic signed [ERR_W-1:0]   error;

	modport source (output valid, output drive, output unlimited_sum, output error,
		input ready);
	modport sink (input valid, input drive, input unlimited_sum, input error,
		output ready);
endinterface

>>> sv/piaw_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI regulator register file
// APB-style configuration registers for gains, divisors and limits.
// ----------------------------------------------------------------------------
module piaw_regs import piaw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= PROP_GAIN_RST;
			cfg_q.prop_divisor  <= PROP_DIVISOR_RST;
			cfg_q.integ_gain    <= INTEG_GAIN_RST;
			cfg_q.integ_divisor <= INTEG_DIVISOR_RST;
			cfg_q.out_upper     <= OUT_UPPER_RST;
			cfg_q.out_lower     <= OUT_LOWER_RST;
			cfg_q.integ_upper   <= INTEG_UPPER_RST;
			cfg_q.integ_lower   <= INTEG_LOWER_RST;
		end else if (wr_en) begin
			case (idx)
				REG_PROP_GAIN:     cfg_q.prop_gain     <= pwdata[GAIN_W-1:0];
				REG_PROP_DIVISOR:  cfg_q.prop_divisor  <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN:    cfg_q.integ_gain    <= pwdata[GAIN_W-1:0];
				REG_INTEG_DIVISOR: cfg_q.integ_divisor <= pwdata[GAIN_W-1:0];
				REG_OUT_UPPER:     cfg_q.out_upper     <= pwdata[LIMIT_W-1:0];
				REG_OUT_LOWER:     cfg_q.out_lower     <= pwdata[LIMIT_W-1:0];
				REG_INTEG_UPPER:   cfg_q.integ_upper   <= pwdata[WIDE_W-1:0];
				REG_INTEG_LOWER:   cfg_q.integ_lower   <= pwdata[WIDE_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PROP_GAIN:     prdata = APB_DATA_W'(cfg_q.prop_gain);
			REG_PROP_DIVISOR:  prdata = APB_DATA_W'(cfg_q.prop_divisor);
			REG_INTEG_GAIN:    prdata = APB_DATA_W'(cfg_q.integ_gain);
			REG_INTEG_DIVISOR: prdata = APB_DATA_W'(cfg_q.integ_divisor);
			REG_OUT_UPPER:     prdata = APB_DATA_W'($unsigned(cfg_q.out_upper));
			REG_OUT_LOWER:     prdata = APB_DATA_W'($unsigned(cfg_q.out_lower));
			REG_INTEG_UPPER:   prdata = $unsigned(cfg_q.integ_upper);
			REG_INTEG_LOWER:   prdata = $unsigned(cfg_q.integ_lower);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> sv/piaw_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI regulator serial multiplier
// Multiplies the signed error by an unsigned gain, one gain bit per cycle,
// most significant bit first.
// ----------------------------------------------------------------------------
module piaw_mul import piaw_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [ERR_W-1:0]  mcand,
	input  logic [GAIN_W-1:0]        mplr,
	output logic                     done,
	output logic signed [PROD_W-1:0] product
);

	logic signed [PROD_W-1:0] acc_q;
	logic signed [ERR_W-1:0]  mcand_q;
	logic [GAIN_W-1:0]        mplr_q;
	logic [MUL_CNT_W-1:0]     cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [PROD_W-1:0] addend;

	assign addend  = mplr_q[GAIN_W-1] ?
		$signed({{(PROD_W-ERR_W){mcand_q[ERR_W-1]}}, mcand_q}) : '0;
	assign done    = done_q;
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == MUL_CNT_W'(1));
			if (start) begin
				cnt_q  <= MUL_CNT_W'(MUL_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mcand_q <= mcand;
			mplr_q  <= mplr;
		end else if (busy_q) begin
			acc_q  <= (acc_q <<< 1) + addend;
			mplr_q <= mplr_q << 1;
		end
	end

endmodule

>>> sv/piaw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI regulator serial divider
// Restoring divider, one quotient bit per cycle, for a signed 32-bit dividend
// and an unsigned 15-bit divisor; the quotient truncates toward zero.
// ----------------------------------------------------------------------------
module piaw_div import piaw_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [WIDE_W-1:0] dividend,
	input  logic [GAIN_W-1:0]        divisor,
	output logic                     busy,
	output logic                     done,
	output logic signed [WIDE_W-1:0] quotient
);

	logic [WIDE_W-1:0]    mag_q;
	logic [REM_W-1:0]     rem_q;
	logic [GAIN_W-1:0]    dsr_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [REM_W-1:0]     rem_sh;
	logic                 fits;

	assign rem_sh   = {rem_q[REM_W-2:0], mag_q[WIDE_W-1]};
	assign fits     = rem_sh >= {1'b0, dsr_q};
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? $signed(-mag_q) : $signed(mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// A divisor register holding zero divides by one.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[WIDE_W-1] ? -$unsigned(dividend) : $unsigned(dividend);
			neg_q <= dividend[WIDE_W-1];
			dsr_q <= (divisor == '0) ? GAIN_W'(1) : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			mag_q <= {mag_q[WIDE_W-2:0], fits};
		end
	end

endmodule

>>> sv/pi_regulator_antiwindup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI regulator with back-calculation anti-windup
// One sample is processed at a time: a sample beat is accepted only in idle,
// then the 15-step serial multiply is followed by two 32-step serial
// divisions on one shared divider before the result beat is produced.
// A new sample is taken while the previous result still waits to be taken.
// Reset clears the integrator, the saturation error and restores the registers.
// ----------------------------------------------------------------------------
module pi_regulator_antiwindup_unit import piaw_pkg::*; #(
	parameter int ANTIWINDUP_GAIN = ANTIWINDUP_GAIN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	piaw_in_if.sink               samples,
	piaw_out_if.source            results
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_ACC   = 4'd2;
	localparam logic [3:0] ST_CLAMP = 4'd3;
	localparam logic [3:0] ST_DIV_P = 4'd4;
	localparam logic [3:0] ST_DIV_I = 4'd5;
	localparam logic [3:0] ST_LIMIT = 4'd6;
	localparam logic [3:0] ST_FEED  = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	localparam logic signed [ACC_W-1:0] AW_GAIN = ACC_W'(ANTIWINDUP_GAIN);

	cfg_t                      cfg;
	logic [3:0]                state_q;
	logic                      accept;
	logic signed [ERR_W-1:0]   err_in;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [WIDE_W-1:0]  integ_q;
	logic signed [WIDE_W-1:0]  sat_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [WIDE_W-1:0]  pterm_q;
	logic signed [WIDE_W-1:0]  sum_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] out_drive_q;
	logic signed [WIDE_W-1:0]  out_sum_q;
	logic signed [ERR_W-1:0]   out_err_q;

	logic                      pmul_done;
	logic                      imul_done;
	logic signed [PROD_W-1:0]  prop_prod;
	logic signed [PROD_W-1:0]  integ_prod;

	logic                      div_start;
	logic signed [WIDE_W-1:0]  div_dividend;
	logic [GAIN_W-1:0]         div_divisor;
	logic                      div_busy;
	logic                      div_done;
	logic signed [WIDE_W-1:0]  quotient;

	logic signed [ACC_W-1:0]   acc_next;
	logic signed [ACC_W-1:0]   iup_ext;
	logic signed [ACC_W-1:0]   ilo_ext;
	logic signed [WIDE_W:0]    sum_wide;
	logic signed [CMP_W-1:0]   sum20;
	logic signed [CMP_W-1:0]   oup19;
	logic signed [CMP_W-1:0]   olo19;
	logic signed [CMP_W-1:0]   sum_ext;
	logic signed [CMP_W-1:0]   oup_ext;
	logic signed [CMP_W-1:0]   olo_ext;
	logic signed [WIDE_W:0]    sat_wide;
	logic                      out_free;

	piaw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign err_in        = $signed({samples.reference[SAMP_W-1], samples.reference})
		- $signed({samples.feedback[SAMP_W-1], samples.feedback});

	piaw_mul u_pmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.mcand   (err_in),
		.mplr    (cfg.prop_gain),
		.done    (pmul_done),
		.product (prop_prod)
	);

	piaw_mul u_imul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.mcand   (err_in),
		.mplr    (cfg.integ_gain),
		.done    (imul_done),
		.product (integ_prod)
	);

	// The divider serves the proportional term first, then the integral term.
	assign div_start    = (state_q == ST_CLAMP) || ((state_q == ST_DIV_P) && div_done);
	assign div_dividend = (state_q == ST_CLAMP) ? prop_prod : integ_q;
	assign div_divisor  = (state_q == ST_CLAMP) ? cfg.prop_divisor : cfg.integ_divisor;

	piaw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	assign acc_next = $signed({{(ACC_W-WIDE_W){integ_q[WIDE_W-1]}}, integ_q})
		+ $signed({{(ACC_W-PROD_W){integ_prod[PROD_W-1]}}, integ_prod})
		+ $signed({{(ACC_W-WIDE_W){sat_q[WIDE_W-1]}}, sat_q}) * AW_GAIN;
	assign iup_ext  = $signed({{(ACC_W-WIDE_W){cfg.integ_upper[WIDE_W-1]}}, cfg.integ_upper});
	assign ilo_ext  = $signed({{(ACC_W-WIDE_W){cfg.integ_lower[WIDE_W-1]}}, cfg.integ_lower});

	assign sum_wide = $signed({pterm_q[WIDE_W-1], pterm_q})
		+ $signed({quotient[WIDE_W-1], quotient});

	assign sum_ext = $signed({{(CMP_W-WIDE_W){sum_q[WIDE_W-1]}}, sum_q});
	assign oup_ext = $signed({{(CMP_W-LIMIT_W){cfg.out_upper[LIMIT_W-1]}}, cfg.out_upper});
	assign olo_ext = $signed({{(CMP_W-LIMIT_W){cfg.out_lower[LIMIT_W-1]}}, cfg.out_lower});
	assign sum20   = (sum_ext <<< 4) + (sum_ext <<< 2);
	assign oup19   = (oup_ext <<< 4) + (oup_ext <<< 1) + oup_ext;
	assign olo19   = (olo_ext <<< 4) + (olo_ext <<< 1) + olo_ext;

	assign sat_wide = $signed({{(WIDE_W+1-DRIVE_W){drive_q[DRIVE_W-1]}}, drive_q})
		- $signed({sum_q[WIDE_W-1], sum_q});

	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			integ_q     <= '0;
			sat_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (pmul_done && imul_done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: state_q <= ST_CLAMP;
				ST_CLAMP: begin
					// The upper clamp wins when the two clamps cross.
					if (cfg.integ_gain == '0) begin
						integ_q <= '0;
					end else if (acc_q > iup_ext) begin
						integ_q <= cfg.integ_upper;
					end else if (acc_q < ilo_ext) begin
						integ_q <= cfg.integ_lower;
					end else begin
						integ_q <= acc_q[WIDE_W-1:0];
					end
					state_q <= ST_DIV_P;
				end
				ST_DIV_P: begin
					if (div_done) begin
						state_q <= ST_DIV_I;
					end
				end
				ST_DIV_I: begin
					if (div_done) begin
						state_q <= ST_LIMIT;
					end
				end
				ST_LIMIT: state_q <= ST_FEED;
				ST_FEED: begin
					sat_q   <= sat33(sat_wide);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= err_in;
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_next;
		end
		if ((state_q == ST_DIV_P) && div_done) begin
			pterm_q <= quotient;
		end
		if ((state_q == ST_DIV_I) && div_done) begin
			sum_q <= sat33(sum_wide);
		end
		if (state_q == ST_LIMIT) begin
			if (sum20 >= oup19) begin
				drive_q <= cfg.out_upper;
			end else if (sum20 < olo19) begin
				drive_q <= cfg.out_lower;
			end else begin
				drive_q <= sum_q[DRIVE_W-1:0];
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_drive_q <= drive_q;
			out_sum_q   <= sum_q;
			out_err_q   <= err_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.drive         = out_drive_q;
	assign results.unlimited_sum = out_sum_q;
	assign results.error         = out_err_q;

	a_accept_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL))
		else $error("accepted sample did not start the multipliers");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_muls_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		pmul_done == imul_done)
		else $error("multipliers finished out of step");

	a_zero_gain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CLAMP) && (cfg.integ_gain == '0)) |=> (integ_q == '0))
		else $error("integrator not cleared with zero integral gain");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && !out_free) |=> (state_q == ST_DONE))
		else $error("result left the sequencer while the output beat was stalled");

endmodule

>>> tb/sv/pi_regulator_antiwindup_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PI regulator with anti-windup testbench
// Drives reference/feedback beats through the regulator and checks every
// result beat against a cycle-free PI predictor with back-calculation
// anti-windup. The register port is exercised with read-back, and the run
// mixes idling and stalls on both channels with a long result hold-off.
// ----------------------------------------------------------------------------
module pi_regulator_antiwindup_unit_tb;
	import piaw_pkg::*;

	localparam int WINDUP_GAIN   = ANTIWINDUP_GAIN_DEF;
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 200;
	localparam int PHASES        = 30;
	localparam int PHASE_ITEMS   = 52;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [WIDE_W-1:0]  unlimited_sum;
		logic signed [ERR_W-1:0]   error;
	} pi_result_t;

	typedef struct {
		bit                       is_reg;
		logic [REG_IDX_W-1:0]     idx;
		logic [APB_DATA_W-1:0]    value;
		logic signed [SAMP_W-1:0] target;
		logic signed [SAMP_W-1:0] measured;
		bit                       known;
		pi_result_t               want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	piaw_in_if  sample_ch ();
	piaw_out_if result_ch ();

	pi_regulator_antiwindup_unit #(
		.ANTIWINDUP_GAIN(WINDUP_GAIN)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (sample_ch.sink),
		.results (result_ch.source)
	);

	always #2 clk = ~clk;

	// Predictor state: register copy, integrator and stored saturation error.
	cfg_t       settings;
	longint     integ_state;
	longint     sat_state;
	pi_result_t expected_results [$];
	plan_row_t  plan_q [$];

	bit         next_known;
	pi_result_t known_want;
	int         tx_idle_pct;
	int         rx_idle_pct;
	bit         hold_off_req;
	int         mismatches;
	int         result_beats;
	int         quiet_cycles;
	int         sample_corners [4] = '{-32768, -1, 0, 32767};

	function automatic longint clip_s32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [SAMP_W-1:0] to_s16(input int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[SAMP_W-1:0];
	endfunction

	// One control step: integrator update, P+I sum, output limiting at 95 %.
	function automatic void pi_step(input logic signed [SAMP_W-1:0] target,
		input logic signed [SAMP_W-1:0] measured, output pi_result_t res);
		longint kp, kpd, ki, kid, oup, olo, iup, ilo, err, acc, sum, drv;
		kp  = longint'(settings.prop_gain);
		kpd = longint'(settings.prop_divisor);
		ki  = longint'(settings.integ_gain);
		kid = longint'(settings.integ_divisor);
		oup = longint'($signed(settings.out_upper));
		olo = longint'($signed(settings.out_lower));
		iup = longint'($signed(settings.integ_upper));
		ilo = longint'($signed(settings.integ_lower));
		if (kpd == 0) kpd = 1;
		if (kid == 0) kid = 1;
		err = longint'(target) - longint'(measured);
		if (ki == 0) begin
			integ_state = 0;
		end else begin
			acc = integ_state + ki * err + longint'(WINDUP_GAIN) * sat_state;
			// The upper clamp wins when the clamps are crossed.
			if (acc > iup) integ_state = iup;
			else if (acc < ilo) integ_state = ilo;
			else integ_state = acc;
		end
		sum = clip_s32(kp * err / kpd + integ_state / kid);
		if (20 * sum >= 19 * oup) drv = oup;
		else if (20 * sum < 19 * olo) drv = olo;
		else drv = sum;
		sat_state = clip_s32(drv - sum);
		res.drive         = drv[DRIVE_W-1:0];
		res.unlimited_sum = sum[WIDE_W-1:0];
		res.error         = err[ERR_W-1:0];
	endfunction

	function automatic void apply_setting(input logic [REG_IDX_W-1:0] idx,
		input logic [APB_DATA_W-1:0] v);
		case (idx)
			REG_PROP_GAIN:     settings.prop_gain     = v[GAIN_W-1:0];
			REG_PROP_DIVISOR:  settings.prop_divisor  = v[GAIN_W-1:0];
			REG_INTEG_GAIN:    settings.integ_gain    = v[GAIN_W-1:0];
			REG_INTEG_DIVISOR: settings.integ_divisor = v[GAIN_W-1:0];
			REG_OUT_UPPER:     settings.out_upper     = v[LIMIT_W-1:0];
			REG_OUT_LOWER:     settings.out_lower     = v[LIMIT_W-1:0];
			REG_INTEG_UPPER:   settings.integ_upper   = v[WIDE_W-1:0];
			REG_INTEG_LOWER:   settings.integ_lower   = v[WIDE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [APB_DATA_W-1:0] setting_bits(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_PROP_GAIN:     return {17'd0, settings.prop_gain};
			REG_PROP_DIVISOR:  return {17'd0, settings.prop_divisor};
			REG_INTEG_GAIN:    return {17'd0, settings.integ_gain};
			REG_INTEG_DIVISOR: return {17'd0, settings.integ_divisor};
			REG_OUT_UPPER:     return {16'd0, settings.out_upper};
			REG_OUT_LOWER:     return {16'd0, settings.out_lower};
			REG_INTEG_UPPER:   return settings.integ_upper;
			default:           return settings.integ_lower;
		endcase
	endfunction

	function automatic logic [APB_DATA_W-1:0] reg_mask(input logic [REG_IDX_W-1:0] idx);
		if (idx == REG_INTEG_UPPER || idx == REG_INTEG_LOWER) return 32'hffff_ffff;
		if (idx == REG_OUT_UPPER || idx == REG_OUT_LOWER) return 32'h0000_ffff;
		return 32'h0000_7fff;
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(input int unsigned typical_max);
		case ($urandom_range(5))
			0:       return '0;
			1:       return 15'h7fff;
			2:       return 15'd1;
			3, 4:    return GAIN_W'($urandom_range(typical_max, 1));
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	function automatic void plan_reg(input logic [REG_IDX_W-1:0] idx,
		input logic [APB_DATA_W-1:0] v);
		plan_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.idx    = idx;
		row.value  = v;
		plan_q.push_back(row);
	endfunction

	function automatic void plan_sample(input int target, input int measured,
		input bit known = 1'b0, input int drive = 0, input int sum = 0, input int err = 0);
		plan_row_t row;
		row = '{default: '0};
		row.target             = target[SAMP_W-1:0];
		row.measured           = measured[SAMP_W-1:0];
		row.known              = known;
		row.want.drive         = drive[DRIVE_W-1:0];
		row.want.unlimited_sum = sum;
		row.want.error         = err[ERR_W-1:0];
		plan_q.push_back(row);
	endfunction

	task automatic reg_access(input bit wr, input logic [REG_IDX_W-1:0] idx,
		input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = {idx, 2'b00};
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Bits above the register width carry noise; the block must ignore them.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] v);
		logic [APB_DATA_W-1:0] mask, wdata, rd;
		mask  = reg_mask(idx);
		wdata = (v & mask) | ($urandom() & ~mask);
		reg_access(1'b1, idx, wdata, rd);
		apply_setting(idx, wdata);
		reg_access(1'b0, idx, '0, rd);
		if ((rd & mask) !== setting_bits(idx))
			flag_mismatch($sformatf("register %0d reads %h, written %h", idx, rd & mask,
				setting_bits(idx)));
	endtask

	task automatic wait_drained();
		sample_ch.valid = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_sample(input logic signed [SAMP_W-1:0] target,
		input logic signed [SAMP_W-1:0] measured, input bit known, input pi_result_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid = 1'b0;
			@(negedge clk);
		end
		next_known          = known;
		known_want          = want;
		sample_ch.valid     = 1'b1;
		sample_ch.reference = target;
		sample_ch.feedback  = measured;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	task automatic randomise_settings();
		logic [APB_DATA_W-1:0] up, lo;
		write_reg(REG_PROP_GAIN, APB_DATA_W'(pick_gain(8000)));
		write_reg(REG_PROP_DIVISOR, APB_DATA_W'(pick_gain(512)));
		write_reg(REG_INTEG_GAIN, APB_DATA_W'(pick_gain(64)));
		write_reg(REG_INTEG_DIVISOR, APB_DATA_W'(pick_gain(16)));
		case ($urandom_range(7))
			0: begin
				up = 32'd32767;
				lo = -32'sd32768;
			end
			1: begin
				up = $urandom();
				lo = $urandom();
			end
			default: begin
				up = $urandom_range(32767, 100);
				lo = -$urandom_range(32768, 100);
			end
		endcase
		write_reg(REG_OUT_UPPER, up);
		write_reg(REG_OUT_LOWER, lo);
		case ($urandom_range(7))
			0: begin
				up = 32'h7fff_ffff;
				lo = 32'h8000_0000;
			end
			1: begin
				up = $urandom();
				lo = $urandom();
			end
			default: begin
				up = $urandom_range(1 << 20, 1);
				lo = -$urandom_range(1 << 20, 1);
			end
		endcase
		write_reg(REG_INTEG_UPPER, up);
		write_reg(REG_INTEG_LOWER, lo);
	endtask

	// Scoreboard: the predictor runs on every accepted sample beat.
	always @(posedge clk) begin
		pi_result_t want, predicted;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				result_beats++;
				if (expected_results.size() == 0) begin
					flag_mismatch($sformatf("result beat %0d with nothing expected, drive %0d",
						result_beats, result_ch.drive));
				end else begin
					want = expected_results.pop_front();
					if (result_ch.drive !== want.drive)
						flag_mismatch($sformatf("beat %0d drive %0d, expected %0d",
							result_beats, result_ch.drive, want.drive));
					if (result_ch.unlimited_sum !== want.unlimited_sum)
						flag_mismatch($sformatf("beat %0d unlimited_sum %0d, expected %0d",
							result_beats, result_ch.unlimited_sum, want.unlimited_sum));
					if (result_ch.error !== want.error)
						flag_mismatch($sformatf("beat %0d error %0d, expected %0d",
							result_beats, result_ch.error, want.error));
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				pi_step(sample_ch.reference, sample_ch.feedback, predicted);
				expected_results.push_back(next_known ? known_want : predicted);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) ||
			(result_ch.valid && result_ch.ready) || (psel && penable && pready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off so the block backs up.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left       = 0;
		hold_done       = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready = 1'b0;
				hold_left--;
			end else begin
				result_ch.ready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		pi_result_t               none;
		logic signed [SAMP_W-1:0] target, measured;
		int                       setpoint;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.reference = '0;
		sample_ch.feedback  = '0;
		none                = '{default: '0};
		next_known          = 1'b0;
		known_want          = none;
		hold_off_req        = 1'b0;
		mismatches          = 0;
		result_beats        = 0;
		quiet_cycles        = 0;
		setpoint            = 0;
		settings = '{PROP_GAIN_RST, PROP_DIVISOR_RST, INTEG_GAIN_RST, INTEG_DIVISOR_RST,
			OUT_UPPER_RST, OUT_LOWER_RST, INTEG_UPPER_RST, INTEG_LOWER_RST};
		integ_state = 0;
		sat_state   = 0;
		tx_idle_pct = 15;
		rx_idle_pct = 75;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values, then the full error swing both ways.
		plan_sample(0, 0, 1'b1, 0, 0, 0);
		plan_sample(32767, -32768, 1'b1, 6000, 4101937, 65535);
		plan_sample(-32768, 32767, 1'b1, -6000, -4101937, -65535);
		plan_sample(-32768, -32768);
		plan_sample(32767, 32767);
		plan_sample(-1, 0);
		plan_sample(21845, -21846);
		// With no integral gain the integrator is cleared every beat.
		plan_reg(REG_INTEG_GAIN, 0);
		plan_sample(1000, -1000);
		plan_sample(-2500, 500);
		// Divisors of zero behave as one.
		plan_reg(REG_PROP_DIVISOR, 0);
		plan_reg(REG_INTEG_DIVISOR, 0);
		plan_reg(REG_INTEG_GAIN, 5);
		plan_sample(100, 0);
		plan_sample(-100, 0);
		plan_reg(REG_INTEG_UPPER, -100);
		plan_reg(REG_INTEG_LOWER, 100);
		plan_sample(50, 0);
		plan_sample(-50, 0);
		plan_reg(REG_INTEG_UPPER, 6000);
		plan_reg(REG_INTEG_LOWER, -6000);
		plan_reg(REG_OUT_UPPER, -1000);
		plan_reg(REG_OUT_LOWER, 1000);
		plan_sample(0, 0);
		plan_sample(10, 0);
		plan_sample(-3000, 0);
		// Clear the state, wind the integrator close to its top, then push the sum past
		// the 32-bit range with a negative upper limit so that the saturation
		// error overflows as well.
		plan_reg(REG_PROP_GAIN, 0);
		plan_reg(REG_INTEG_GAIN, 0);
		plan_reg(REG_PROP_DIVISOR, 1);
		plan_reg(REG_INTEG_DIVISOR, 1);
		plan_reg(REG_OUT_UPPER, 32767);
		plan_reg(REG_OUT_LOWER, -32768);
		plan_reg(REG_INTEG_UPPER, 32'h7fff_ffff);
		plan_reg(REG_INTEG_LOWER, 32'h8000_0000);
		plan_sample(0, 0);
		plan_reg(REG_INTEG_GAIN, 32767);
		plan_sample(32767, -32768);
		plan_reg(REG_PROP_GAIN, 32767);
		plan_reg(REG_INTEG_GAIN, 2);
		plan_reg(REG_OUT_UPPER, -2);
		plan_sample(32767, -32768);
		plan_sample(-32768, 32767);

		foreach (plan_q[i]) begin
			if (plan_q[i].is_reg) begin
				wait_drained();
				write_reg(plan_q[i].idx, plan_q[i].value);
			end else begin
				send_sample(plan_q[i].target, plan_q[i].measured, plan_q[i].known,
					plan_q[i].want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase / (PHASES / 3))
				0: begin
					tx_idle_pct = 15;
					rx_idle_pct = 75;
				end
				1: begin
					tx_idle_pct = 75;
					rx_idle_pct = 15;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			wait_drained();
			randomise_settings();
			if (phase == 2 * PHASES / 3) hold_off_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == 2 * PHASES / 3 + 5 && k % 13 == 12) wait_drained();
				if ($urandom_range(19) == 0) setpoint = $urandom_range(65535) - 32768;
				// Mostly a loop that tracks a set-point, with corner and raw noise beats.
				case ($urandom_range(9))
					0: begin
						target   = SAMP_W'(sample_corners[$urandom_range(3)]);
						measured = SAMP_W'(sample_corners[$urandom_range(3)]);
					end
					1, 2, 3, 4, 5: begin
						target   = to_s16(setpoint + $urandom_range(20) - 10);
						measured = to_s16(setpoint + $urandom_range(400) - 200);
					end
					default: begin
						target   = SAMP_W'($urandom());
						measured = SAMP_W'($urandom());
					end
				endcase
				send_sample(target, measured, 1'b0, none);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/piaw_pkg.sv
sv/piaw_in_if.sv
sv/piaw_out_if.sv
sv/piaw_regs.sv
sv/piaw_mul.sv
sv/piaw_div.sv
sv/pi_regulator_antiwindup_unit.sv
tb/sv/pi_regulator_antiwindup_unit_tb.sv
